FILE: src/ppucpu_pkg.sv
// Package for the picture-unit CPU register port: operation and register codes,
// bit masks of the scroll and status logic, and the controller state and command types.
// No dependencies; the controller, datapath, top level and testbench import it.
package ppucpu_pkg;

	localparam int unsigned SPRITE_BYTES   = 256;
	localparam int unsigned VRAM_ADDR_BITS = 14;
	localparam int unsigned OAM_ADDR_BITS  = $clog2(SPRITE_BYTES);

	// Item operations.
	localparam logic [2:0] OP_READ   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_RETURN = 3'd2;
	localparam logic [2:0] OP_STATUS = 3'd3;
	localparam logic [2:0] OP_SOFT   = 3'd4;

	// Register indexes.
	localparam logic [2:0] REG_CTRL     = 3'd0;
	localparam logic [2:0] REG_MASK     = 3'd1;
	localparam logic [2:0] REG_STATUS   = 3'd2;
	localparam logic [2:0] REG_OAM_ADDR = 3'd3;
	localparam logic [2:0] REG_OAM_DATA = 3'd4;
	localparam logic [2:0] REG_SCROLL   = 3'd5;
	localparam logic [2:0] REG_ADDR     = 3'd6;
	localparam logic [2:0] REG_DATA     = 3'd7;

	localparam logic [7:0] STATUS_RESET     = 8'hA0;
	localparam logic [7:0] STATUS_FLAGS     = 8'hE0;
	localparam logic [7:0] STATUS_LOW_KEEP  = 8'h1F;
	localparam logic [7:0] VBLANK_CLEAR     = 8'h7F;
	localparam logic [7:0] OAM_ATTR_MASK    = 8'hE3;

	localparam logic [14:0] T_NT_SEL    = 15'h0C00;
	localparam logic [14:0] T_COARSE_X  = 15'h001F;
	localparam logic [14:0] T_FINE_Y_CY = 15'h73E0;
	localparam logic [14:0] T_LOW_KEEP  = 15'h00FF;
	localparam logic [14:0] T_HIGH_KEEP = 15'h7F00;

	localparam logic [15:0] V_STEP_ROW = 16'd32;
	localparam logic [15:0] V_STEP_COL = 16'd1;

	localparam logic [VRAM_ADDR_BITS-1:0] NT_TAIL = 14'h3EFF;
	localparam logic [VRAM_ADDR_BITS-1:0] NT_MASK = 14'h2FFF;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_cmd_t;

endpackage

FILE: src/ppucpu_cmd_if.sv
// Input channel of the register port: one bus access or control item per beat.
// Depends on nothing.
interface ppucpu_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [2:0] reg_index;
	logic [7:0] write_data;
	logic [7:0] mem_data;
	logic [7:0] nt_data;
	logic [2:0] status_bits;

	modport source (output valid, op, reg_index, write_data, mem_data, nt_data, status_bits,
		input ready);
	modport sink (input valid, op, reg_index, write_data, mem_data, nt_data, status_bits,
		output ready);
endinterface

FILE: src/ppucpu_rsp_if.sv
// Result channel of the register port: one result beat per accepted item.
// Depends on nothing.
interface ppucpu_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        read_valid;
	logic        mem_req;
	logic        mem_write;
	logic [13:0] mem_addr;
	logic [7:0]  mem_wdata;
	logic [13:0] nt_addr;
	logic        nmi_line;
	logic [2:0]  fine_scroll_x;
	logic [15:0] vram_address;
	logic [14:0] temp_address;
	logic        status;

	modport source (output valid, read_data, read_valid, mem_req, mem_write, mem_addr,
		mem_wdata, nt_addr, nmi_line, fine_scroll_x, vram_address, temp_address, status,
		input ready);
	modport sink (input valid, read_data, read_valid, mem_req, mem_write, mem_addr,
		mem_wdata, nt_addr, nmi_line, fine_scroll_x, vram_address, temp_address, status,
		output ready);
endinterface

FILE: src/ppucpu_ctrl.sv
// Controller of the register port: accept/execute sequencer and result-valid flag.
// Depends on ppucpu_pkg.
module ppucpu_ctrl import ppucpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ctl_cmd_t ctl
);

	ctl_state_t state_q;
	logic       out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign ctl.capture = in_valid && in_ready;
	assign ctl.execute = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.capture) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.execute) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_capture_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == S_EXEC))
		else $error("accepted item did not enter execution");

	a_exec_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.execute |=> out_valid_q)
		else $error("executed item produced no result beat");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && out_valid_q && !out_ready |=> (state_q == S_EXEC))
		else $error("item left execution while the result register was full");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state lost its one-hot code");

endmodule

FILE: src/ppucpu_dp.sv
// Datapath of the register port: captured item, register bytes, loopy v/t/fine x,
// sprite memory, read buffer, open-bus latch and the result register. Depends on ppucpu_pkg.
module ppucpu_dp import ppucpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    ctl,
	input  logic [2:0]  op,
	input  logic [2:0]  reg_index,
	input  logic [7:0]  write_data,
	input  logic [7:0]  mem_data,
	input  logic [7:0]  nt_data,
	input  logic [2:0]  status_bits,
	output logic [7:0]  read_data,
	output logic        read_valid,
	output logic        mem_req,
	output logic        mem_write,
	output logic [13:0] mem_addr,
	output logic [7:0]  mem_wdata,
	output logic [13:0] nt_addr,
	output logic        nmi_line,
	output logic [2:0]  fine_scroll_x,
	output logic [15:0] vram_address,
	output logic [14:0] temp_address,
	output logic        status
);

	// Captured item.
	logic [2:0] op_q, reg_q, sb_q;
	logic [7:0] wd_q, md_q, nd_q;

	// Architectural state.
	logic [7:0]  rf_q [8];
	logic [15:0] v_q;
	logic [14:0] t_q;
	logic [2:0]  fx_q;
	logic        tg_q, pend_q;
	logic [7:0]  buf_q, lat_q;

	logic [7:0] oam_mem [SPRITE_BYTES];
	logic [7:0] oam_rd_q;

	// Next state and result.
	logic [7:0]  rf_n [8];
	logic [15:0] v_n, vinc;
	logic [14:0] t_n;
	logic [2:0]  fx_n;
	logic        tg_n, pend_n;
	logic [7:0]  buf_n, lat_n, val;
	logic [7:0]  rdata, mwd, oam_wd;
	logic        rvalid, req, mwr, ign, oam_we;
	logic [VRAM_ADDR_BITS-1:0] maddr;

	always_comb begin
		rf_n   = rf_q;
		v_n    = v_q;
		t_n    = t_q;
		fx_n   = fx_q;
		tg_n   = tg_q;
		pend_n = pend_q;
		buf_n  = buf_q;
		lat_n  = lat_q;
		val    = lat_q;
		rdata  = '0;
		rvalid = 1'b0;
		req    = 1'b0;
		mwr    = 1'b0;
		maddr  = '0;
		mwd    = '0;
		ign    = 1'b0;
		oam_we = 1'b0;
		oam_wd = wd_q;
		vinc   = rf_q[REG_CTRL][2] ? V_STEP_ROW : V_STEP_COL;
		priority if (op_q == OP_READ && !pend_q) begin
			unique case (reg_q)
				REG_STATUS: begin
					val              = (rf_q[REG_STATUS] & STATUS_FLAGS) | (lat_q & STATUS_LOW_KEEP);
					rf_n[REG_STATUS] = rf_q[REG_STATUS] & VBLANK_CLEAR;
					tg_n             = 1'b0;
				end
				REG_OAM_DATA: val = oam_rd_q;
				REG_DATA: begin
					req    = 1'b1;
					maddr  = v_q[VRAM_ADDR_BITS-1:0];
					pend_n = 1'b1;
				end
				default: val = lat_q;
			endcase
			if (!req) begin
				lat_n  = val;
				rdata  = val;
				rvalid = 1'b1;
			end
		end else if (op_q == OP_WRITE && !pend_q) begin
			lat_n = wd_q;
			if (reg_q != REG_STATUS) begin
				rf_n[reg_q] = wd_q;
			end
			unique case (reg_q)
				REG_CTRL: t_n = (t_q & ~T_NT_SEL) | {3'b000, wd_q[1:0], 10'd0};
				REG_OAM_DATA: begin
					oam_we = 1'b1;
					oam_wd = (rf_q[REG_OAM_ADDR][1:0] == 2'b10) ? (wd_q & OAM_ATTR_MASK) : wd_q;
					rf_n[REG_OAM_ADDR] = rf_q[REG_OAM_ADDR] + 8'd1;
				end
				REG_SCROLL: begin
					if (!tg_q) begin
						t_n  = (t_q & ~T_COARSE_X) | {10'd0, wd_q[7:3]};
						fx_n = wd_q[2:0];
					end else begin
						t_n = (t_q & ~T_FINE_Y_CY) | {wd_q[2:0], 2'b00, wd_q[7:3], 5'd0};
					end
					tg_n = ~tg_q;
				end
				REG_ADDR: begin
					if (!tg_q) begin
						t_n = (t_q & T_LOW_KEEP) | {1'b0, wd_q[5:0], 8'd0};
					end else begin
						t_n = (t_q & T_HIGH_KEEP) | {7'd0, wd_q};
						v_n = {1'b0, t_n};
					end
					tg_n = ~tg_q;
				end
				REG_DATA: begin
					req   = 1'b1;
					mwr   = 1'b1;
					maddr = v_q[VRAM_ADDR_BITS-1:0];
					mwd   = wd_q;
					v_n   = v_q + vinc;
				end
				default: lat_n = wd_q;
			endcase
		end else if (op_q == OP_RETURN && pend_q) begin
			if (v_q[VRAM_ADDR_BITS-1:0] <= NT_TAIL) begin
				val   = buf_q;
				buf_n = md_q;
			end else begin
				val   = md_q;
				buf_n = nd_q;
			end
			v_n    = v_q + vinc;
			lat_n  = val;
			rdata  = val;
			rvalid = 1'b1;
			pend_n = 1'b0;
		end else if (op_q == OP_STATUS) begin
			rf_n[REG_STATUS] = (rf_q[REG_STATUS] & STATUS_LOW_KEEP) | {sb_q, 5'd0};
		end else if (op_q == OP_SOFT) begin
			rf_n[REG_CTRL]   = '0;
			rf_n[REG_MASK]   = '0;
			rf_n[REG_SCROLL] = '0;
			tg_n   = 1'b0;
			buf_n  = '0;
			lat_n  = '0;
			v_n    = '0;
			t_n    = '0;
			fx_n   = '0;
			pend_n = 1'b0;
		end else begin
			ign = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q  <= op;
			reg_q <= reg_index;
			wd_q  <= write_data;
			md_q  <= mem_data;
			nd_q  <= nt_data;
			sb_q  <= status_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
			rf_q[REG_STATUS] <= STATUS_RESET;
			v_q    <= '0;
			t_q    <= '0;
			fx_q   <= '0;
			tg_q   <= 1'b0;
			pend_q <= 1'b0;
			buf_q  <= '0;
			lat_q  <= '0;
		end else if (ctl.execute) begin
			rf_q   <= rf_n;
			v_q    <= v_n;
			t_q    <= t_n;
			fx_q   <= fx_n;
			tg_q   <= tg_n;
			pend_q <= pend_n;
			buf_q  <= buf_n;
			lat_q  <= lat_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.execute && oam_we) begin
			oam_mem[rf_q[REG_OAM_ADDR][OAM_ADDR_BITS-1:0]] <= oam_wd;
		end
		oam_rd_q <= oam_mem[rf_q[REG_OAM_ADDR][OAM_ADDR_BITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.execute) begin
			read_data     <= rdata;
			read_valid    <= rvalid;
			mem_req       <= req;
			mem_write     <= mwr;
			mem_addr      <= maddr;
			mem_wdata     <= mwd;
			nt_addr       <= maddr & NT_MASK;
			nmi_line      <= rf_n[REG_CTRL][7] & rf_n[REG_STATUS][7];
			fine_scroll_x <= fx_n;
			vram_address  <= v_n;
			temp_address  <= t_n;
			status        <= ign;
		end
	end

endmodule

FILE: src/ppu_cpu_register_port_top.sv
// Top level of the picture-unit CPU register port.
// Depends on ppucpu_pkg, ppucpu_cmd_if, ppucpu_rsp_if, ppucpu_ctrl and ppucpu_dp.
//
//   channel  modport  beat carries
//   cmd      sink     op, reg_index, write_data, mem_data, nt_data, status_bits
//   rsp      source   read_data, read_valid, mem_*, nt_addr, nmi_line, scroll and address view
//
// Each item is captured in the cycle it is accepted, then evaluated in the execute state
// against the register state as it loads the result register; cmd takes no new beat meanwhile.
// The sprite memory is read ahead at the current oam address, so that byte is ready at evaluation.
// A data-port read is two items: the request beat, then a memory-return beat.
// Reset (arst_n) clears the registers (status takes its reset value), v, t, fine x, toggle,
// buffer, latch and the pending read; sprite memory contents are not reset.
// If the result register is still full when an item is evaluated, the item holds in
// execution until rsp takes the waiting beat; cmd stays not ready in the meantime.
module ppu_cpu_register_port_top import ppucpu_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	ppucpu_cmd_if.sink   cmd,
	ppucpu_rsp_if.source rsp
);

	// Command pair from the sequencer to the datapath: capture on acceptance,
	// execute when the result register can take the outcome.
	ctl_cmd_t ctl;

	ppucpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	// The datapath owns all architectural state and the result payload register.
	ppucpu_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.op            (cmd.op),
		.reg_index     (cmd.reg_index),
		.write_data    (cmd.write_data),
		.mem_data      (cmd.mem_data),
		.nt_data       (cmd.nt_data),
		.status_bits   (cmd.status_bits),
		.read_data     (rsp.read_data),
		.read_valid    (rsp.read_valid),
		.mem_req       (rsp.mem_req),
		.mem_write     (rsp.mem_write),
		.mem_addr      (rsp.mem_addr),
		.mem_wdata     (rsp.mem_wdata),
		.nt_addr       (rsp.nt_addr),
		.nmi_line      (rsp.nmi_line),
		.fine_scroll_x (rsp.fine_scroll_x),
		.vram_address  (rsp.vram_address),
		.temp_address  (rsp.temp_address),
		.status        (rsp.status)
	);

endmodule

FILE: dv/tb_top.sv
// Testbench for the picture-unit CPU register port: a directed opening, then random bus
// access sequences, each result beat checked field by field against an in-bench model.
// Depends on ppucpu_pkg, ppucpu_cmd_if, ppucpu_rsp_if and ppu_cpu_register_port_top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ppucpu_pkg::*;

	// Stop point for the random part, counted in beats that the port accepts (not ignored).
	localparam int unsigned ITEM_GOAL = 1250;
	// Longest pause either side draws between beats.
	localparam int unsigned MAX_PAUSE = 18;
	// Watchdog limit, in cycles without a handshake on either channel.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles to watch for stray result beats once nothing is outstanding.
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] mem_data;
		logic [7:0] nt_data;
		logic [2:0] status_bits;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_valid;
		logic        mem_req;
		logic        mem_write;
		logic [13:0] mem_addr;
		logic [7:0]  mem_wdata;
		logic [13:0] nt_addr;
		logic        nmi_line;
		logic [2:0]  fine_scroll_x;
		logic [15:0] vram_address;
		logic [14:0] temp_address;
		logic        status;
	} port_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ppucpu_cmd_if cmd_if ();
	ppucpu_rsp_if rsp_if ();

	ppu_cpu_register_port_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.rsp(rsp_if)
	);

	// Everything the bench drives comes from these, so every input is known from time zero.
	cmd_beat_t cmd_drv = '0;
	logic      cmd_vld = 1'b0;
	logic      rsp_rdy = 1'b0;

	assign cmd_if.valid       = cmd_vld;
	assign cmd_if.op          = cmd_drv.op;
	assign cmd_if.reg_index   = cmd_drv.reg_index;
	assign cmd_if.write_data  = cmd_drv.write_data;
	assign cmd_if.mem_data    = cmd_drv.mem_data;
	assign cmd_if.nt_data     = cmd_drv.nt_data;
	assign cmd_if.status_bits = cmd_drv.status_bits;
	assign rsp_if.ready       = rsp_rdy;

	// Shadow of the port: register bytes, sprite memory, loopy v/t, fine x and friends.
	logic [7:0]  regs [8];
	logic [7:0]  oam_mem [SPRITE_BYTES];
	bit          oam_seen [SPRITE_BYTES];
	logic [15:0] v_addr;
	logic [14:0] t_addr;
	logic [2:0]  fine_x;
	logic        wr_toggle;
	logic        rd_pending;
	logic [7:0]  rd_buffer;
	logic [7:0]  open_bus;

	cmd_beat_t    beat_q [$];
	port_result_t rsp_due [$];
	port_result_t next_due;

	int unsigned mismatches = 0;
	int unsigned useful_beats = 0;
	int unsigned rsp_seen = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cmd_pause = 0;
	int unsigned rsp_pause = 0;
	bit          cmd_calm = 1'b0;
	bit          rsp_calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] rand8();
		return 8'($urandom);
	endfunction

	function automatic logic [2:0] rand3();
		return 3'($urandom);
	endfunction

	// A soft reset keeps status, oam address, the addr byte and sprite memory; a hard one also
	// clears every register byte, puts status back to its reset value and forgets which sprite bytes were written.
	function automatic void clear_port(input bit hard);
		if (hard) begin
			foreach (regs[i]) regs[i] = '0;
			regs[REG_STATUS] = STATUS_RESET;
			foreach (oam_seen[i]) oam_seen[i] = 1'b0;
		end
		regs[REG_CTRL]   = '0;
		regs[REG_MASK]   = '0;
		regs[REG_SCROLL] = '0;
		wr_toggle  = 1'b0;
		rd_buffer  = '0;
		open_bus   = '0;
		v_addr     = '0;
		t_addr     = '0;
		fine_x     = '0;
		rd_pending = 1'b0;
	endfunction

	// ctrl bit 2 picks a step of one row (32) or one column (1).
	function automatic void advance_v();
		v_addr = v_addr + (regs[REG_CTRL][2] ? V_STEP_ROW : V_STEP_COL);
	endfunction

	// Applies one accepted command beat to the shadow and returns the result beat it causes.
	function automatic port_result_t ppu_port_step(input cmd_beat_t b);
		port_result_t r;
		logic [7:0] val;
		logic [7:0] spr;
		logic [OAM_ADDR_BITS-1:0] oa;
		r = '0;
		if (b.op == OP_READ && !rd_pending) begin
			// Write-only registers answer with whatever the open bus holds.
			val = open_bus;
			case (b.reg_index)
				REG_STATUS: begin
					val = (regs[REG_STATUS] & STATUS_FLAGS) | (open_bus & STATUS_LOW_KEEP);
					regs[REG_STATUS] = regs[REG_STATUS] & VBLANK_CLEAR;
					wr_toggle = 1'b0;
				end
				REG_OAM_DATA: val = oam_mem[regs[REG_OAM_ADDR]];
				REG_DATA: begin
					r.mem_req = 1'b1;
					r.mem_addr = v_addr[VRAM_ADDR_BITS-1:0];
					rd_pending = 1'b1;
				end
				default: ;
			endcase
			if (!r.mem_req) begin
				open_bus = val;
				r.read_data = val;
				r.read_valid = 1'b1;
			end
		end else if (b.op == OP_WRITE && !rd_pending) begin
			open_bus = b.write_data;
			if (b.reg_index != REG_STATUS) begin
				regs[b.reg_index] = b.write_data;
				case (b.reg_index)
					REG_CTRL: t_addr = (t_addr & ~T_NT_SEL) | {3'b0, b.write_data[1:0], 10'b0};
					REG_OAM_DATA: begin
						// Attribute bytes lose their three unimplemented bits in memory only.
						oa = regs[REG_OAM_ADDR];
						spr = b.write_data;
						if (oa[1:0] == 2'd2) spr = spr & OAM_ATTR_MASK;
						oam_mem[oa] = spr;
						oam_seen[oa] = 1'b1;
						regs[REG_OAM_ADDR] = oa + 1'b1;
					end
					REG_SCROLL: begin
						if (!wr_toggle) begin
							t_addr = (t_addr & ~T_COARSE_X) | {10'b0, b.write_data[7:3]};
							fine_x = b.write_data[2:0];
						end else begin
							t_addr = (t_addr & ~T_FINE_Y_CY) | {b.write_data[2:0], 12'b0}
								| {5'b0, b.write_data[7:3], 5'b0};
						end
						wr_toggle = ~wr_toggle;
					end
					REG_ADDR: begin
						if (!wr_toggle) begin
							t_addr = (t_addr & T_LOW_KEEP) | {1'b0, b.write_data[5:0], 8'b0};
						end else begin
							t_addr = (t_addr & T_HIGH_KEEP) | {7'b0, b.write_data};
							v_addr = {1'b0, t_addr};
						end
						wr_toggle = ~wr_toggle;
					end
					REG_DATA: begin
						r.mem_req = 1'b1;
						r.mem_write = 1'b1;
						r.mem_addr = v_addr[VRAM_ADDR_BITS-1:0];
						r.mem_wdata = b.write_data;
						advance_v();
					end
					default: ;
				endcase
			end
		end else if (b.op == OP_RETURN && rd_pending) begin
			// Below the palette the CPU sees the old buffer; palette reads come straight
			// through and the buffer takes the nametable byte underneath.
			if (v_addr[VRAM_ADDR_BITS-1:0] <= NT_TAIL) begin
				val = rd_buffer;
				rd_buffer = b.mem_data;
			end else begin
				val = b.mem_data;
				rd_buffer = b.nt_data;
			end
			advance_v();
			open_bus = val;
			r.read_data = val;
			r.read_valid = 1'b1;
			rd_pending = 1'b0;
		end else if (b.op == OP_STATUS) begin
			regs[REG_STATUS] = (regs[REG_STATUS] & STATUS_LOW_KEEP) | {b.status_bits, 5'b0};
		end else if (b.op == OP_SOFT) begin
			clear_port(1'b0);
		end else begin
			r.status = 1'b1;
		end
		r.nt_addr = r.mem_req ? (r.mem_addr & NT_MASK) : '0;
		r.nmi_line = regs[REG_CTRL][7] & regs[REG_STATUS][7];
		r.fine_scroll_x = fine_x;
		r.vram_address = v_addr;
		r.temp_address = t_addr;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("ERROR %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s is %0h, model says %0h", rsp_seen, name,
				got, want));
	endtask

	task automatic check_result();
		port_result_t got;
		port_result_t want;
		got = {rsp_if.read_data, rsp_if.read_valid, rsp_if.mem_req, rsp_if.mem_write,
			rsp_if.mem_addr, rsp_if.mem_wdata, rsp_if.nt_addr, rsp_if.nmi_line,
			rsp_if.fine_scroll_x, rsp_if.vram_address, rsp_if.temp_address, rsp_if.status};
		rsp_seen++;
		if (rsp_due.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing outstanding", rsp_seen));
		end else begin
			want = rsp_due.pop_front();
			check_field("read_data", int'(got.read_data), int'(want.read_data));
			check_field("read_valid", int'(got.read_valid), int'(want.read_valid));
			check_field("mem_req", int'(got.mem_req), int'(want.mem_req));
			check_field("mem_write", int'(got.mem_write), int'(want.mem_write));
			check_field("mem_addr", int'(got.mem_addr), int'(want.mem_addr));
			check_field("mem_wdata", int'(got.mem_wdata), int'(want.mem_wdata));
			check_field("nt_addr", int'(got.nt_addr), int'(want.nt_addr));
			check_field("nmi_line", int'(got.nmi_line), int'(want.nmi_line));
			check_field("fine_scroll_x", int'(got.fine_scroll_x), int'(want.fine_scroll_x));
			check_field("vram_address", int'(got.vram_address), int'(want.vram_address));
			check_field("temp_address", int'(got.temp_address), int'(want.temp_address));
			check_field("status", int'(got.status), int'(want.status));
		end
	endtask

	// Driver. The beat on the bus is run through the model at the edge that accepts it,
	// then the next beat is loaded after a pause drawn per beat. Calm stretches with no
	// pause at all alternate with idle ones so the gaps land on every phase of the port.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld <= 1'b0;
			cmd_drv <= '0;
			cmd_pause = 0;
			clear_port(1'b1);
		end else begin
			if (cmd_vld && cmd_if.ready) begin
				next_due = ppu_port_step(cmd_drv);
				rsp_due.push_back(next_due);
				if (!next_due.status) useful_beats++;
				if ($urandom_range(0, 39) == 0) cmd_calm = !cmd_calm;
				cmd_pause = cmd_calm ? 0 : $urandom_range(0, MAX_PAUSE);
			end
			if (!cmd_vld || cmd_if.ready) begin
				if (cmd_pause != 0) begin
					cmd_pause--;
					cmd_vld <= 1'b0;
				end else if (beat_q.size() != 0) begin
					cmd_drv <= beat_q.pop_front();
					cmd_vld <= 1'b1;
				end else begin
					cmd_vld <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each result beat is checked against the oldest outstanding prediction; after
	// every beat the sink draws a stall of its own, so ready only drops between beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_rdy <= 1'b0;
			rsp_pause = 0;
		end else begin
			if (rsp_if.valid && rsp_rdy) begin
				check_result();
				if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
				rsp_pause = rsp_calm ? 0 : $urandom_range(0, MAX_PAUSE);
			end
			if (rsp_pause != 0) begin
				rsp_pause--;
				rsp_rdy <= 1'b0;
			end else begin
				rsp_rdy <= 1'b1;
			end
		end
	end

	// Watchdog: any long stretch without a handshake on either channel means a hang.
	always @(posedge clk) begin
		if (!arst_n || (cmd_vld && cmd_if.ready) || (rsp_if.valid && rsp_rdy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_beat(input logic [2:0] op, input logic [2:0] idx,
		input logic [7:0] wd, input logic [7:0] md, input logic [7:0] nd, input logic [2:0] sb);
		beat_q.push_back(cmd_beat_t'{op, idx, wd, md, nd, sb});
	endtask

	// A CPU access; the memory-return and status fields carry random noise.
	task automatic queue_access(input logic [2:0] op, input logic [2:0] idx, input logic [7:0] wd);
		queue_beat(op, idx, wd, rand8(), rand8(), rand3());
	endtask

	task automatic wait_drained();
		while (beat_q.size() != 0 || cmd_vld) @(negedge clk);
	endtask

	// Sprite memory is undefined until written, so a sprite data read is only sent once the
	// model has caught up and knows the byte at the oam address is real. Otherwise that
	// byte gets written instead. While a data read is pending the access is ignored anyway.
	task automatic queue_oam_read();
		wait_drained();
		if (rd_pending || oam_seen[regs[REG_OAM_ADDR]])
			queue_access(OP_READ, REG_OAM_DATA, rand8());
		else
			queue_access(OP_WRITE, REG_OAM_DATA, rand8());
	endtask

	// Any op, valid or not, with every field random; a sprite data read goes through queue_oam_read.
	task automatic queue_noise();
		logic [2:0] op;
		logic [2:0] idx;
		op = rand3();
		idx = rand3();
		if (op == OP_READ && idx == REG_OAM_DATA)
			queue_oam_read();
		else
			queue_beat(op, idx, rand8(), rand8(), rand8(), rand3());
	endtask

	initial begin
		int unsigned pick;
		int unsigned n;
		logic [7:0] a;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Status read straight after reset returns vblank set and clears it.
		queue_access(OP_READ, REG_STATUS, rand8());
		// A write-only register reads back the open bus; a status write only loads the bus.
		queue_access(OP_READ, REG_CTRL, rand8());
		queue_access(OP_WRITE, REG_STATUS, 8'h5A);
		queue_access(OP_READ, REG_MASK, rand8());
		// All ctrl bits: both nametable select bits, step of 32, nmi enable.
		queue_access(OP_WRITE, REG_CTRL, 8'hFF);
		queue_beat(OP_STATUS, rand3(), rand8(), rand8(), rand8(), 3'b111);
		queue_access(OP_WRITE, REG_SCROLL, 8'hFF);
		queue_access(OP_WRITE, REG_SCROLL, 8'h00);
		// Last address below the palette: the buffered path.
		queue_access(OP_WRITE, REG_ADDR, 8'h3E);
		queue_access(OP_WRITE, REG_ADDR, 8'hFF);
		queue_access(OP_READ, REG_DATA, 8'h00);
		queue_beat(OP_RETURN, REG_CTRL, 8'h00, 8'hFF, 8'h00, 3'b000);
		// Next read: register traffic is ignored while it waits, a status update is not.
		queue_access(OP_READ, REG_DATA, 8'h00);
		queue_access(OP_WRITE, REG_CTRL, 8'h84);
		queue_access(OP_READ, REG_STATUS, 8'h00);
		queue_beat(OP_STATUS, REG_CTRL, 8'h00, 8'h00, 8'h00, 3'b100);
		// Palette range now: data comes straight through, buffer takes the nametable byte.
		queue_beat(OP_RETURN, REG_CTRL, 8'h00, 8'h00, 8'hFF, 3'b000);
		// A return with no read waiting.
		queue_beat(OP_RETURN, REG_DATA, 8'hFF, 8'hFF, 8'hFF, 3'b111);
		// Attribute byte masking and oam address wrap, then read the masked byte back.
		queue_access(OP_WRITE, REG_OAM_ADDR, 8'hFE);
		queue_access(OP_WRITE, REG_OAM_DATA, 8'hFF);
		queue_access(OP_WRITE, REG_OAM_DATA, 8'h00);
		queue_access(OP_WRITE, REG_OAM_ADDR, 8'hFE);
		queue_oam_read();
		queue_access(OP_WRITE, REG_DATA, 8'hFF);
		// Codes above soft reset are not operations.
		for (int k = 1; k <= 3; k++)
			queue_beat(OP_SOFT + 3'(k), rand3(), rand8(), rand8(), rand8(), rand3());
		// Soft reset drops a pending read.
		queue_access(OP_READ, REG_DATA, 8'h00);
		queue_beat(OP_SOFT, rand3(), rand8(), rand8(), rand8(), rand3());
		// Top bits of the high address byte are dropped.
		queue_access(OP_WRITE, REG_ADDR, 8'hFF);
		queue_access(OP_WRITE, REG_ADDR, 8'hFF);

		while (useful_beats < ITEM_GOAL) begin
			while (beat_q.size() > 6) @(negedge clk);
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// Aim v, often at the palette, then a few data-port reads and writes.
				if ($urandom_range(0, 1)) queue_access(OP_READ, REG_STATUS, rand8());
				a = rand8();
				if ($urandom_range(0, 3) == 0) a[5:0] = 6'h3F;
				queue_access(OP_WRITE, REG_ADDR, a);
				queue_access(OP_WRITE, REG_ADDR, rand8());
				n = $urandom_range(1, 4);
				repeat (n) begin
					if ($urandom_range(0, 1)) begin
						queue_access(OP_READ, REG_DATA, rand8());
						queue_beat(OP_RETURN, rand3(), rand8(), rand8(), rand8(), rand3());
					end else begin
						queue_access(OP_WRITE, REG_DATA, rand8());
					end
				end
			end else if (pick < 35) begin
				// Data read, now and then with stray traffic before its return.
				queue_access(OP_READ, REG_DATA, rand8());
				if ($urandom_range(0, 2) == 0) begin
					n = $urandom_range(1, 3);
					repeat (n) queue_noise();
				end
				queue_beat(OP_RETURN, rand3(), rand8(), rand8(), rand8(), rand3());
			end else if (pick < 45) begin
				if ($urandom_range(0, 1)) queue_access(OP_READ, REG_STATUS, rand8());
				queue_access(OP_WRITE, REG_SCROLL, rand8());
				queue_access(OP_WRITE, REG_SCROLL, rand8());
			end else if (pick < 55) begin
				queue_access(OP_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK, rand8());
			end else if (pick < 67) begin
				// Fill a few sprite bytes, step back into the run and read one of them.
				a = rand8();
				n = $urandom_range(1, 4);
				queue_access(OP_WRITE, REG_OAM_ADDR, a);
				repeat (n) queue_access(OP_WRITE, REG_OAM_DATA, rand8());
				queue_access(OP_WRITE, REG_OAM_ADDR, a + 8'($urandom_range(0, n - 1)));
				queue_oam_read();
			end else if (pick < 77) begin
				if ($urandom_range(0, 1)) queue_access(OP_READ, REG_STATUS, rand8());
				queue_beat(OP_STATUS, rand3(), rand8(), rand8(), rand8(), rand3());
			end else if (pick < 79) begin
				queue_beat(OP_SOFT, rand3(), rand8(), rand8(), rand8(), rand3());
			end else begin
				queue_noise();
			end
		end

		wait_drained();
		while (rsp_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
